// ===== rtl/lvl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvl_pkg
// Shared types and codes for the LRU victim list with pin counts.
// ----------------------------------------------------------------------------
package lvl_pkg;

  localparam int FRAME_W = 6;

  // Request codes.
  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_TOUCH   = 3'd1;
  localparam logic [2:0] REQ_EVICT   = 3'd2;
  localparam logic [2:0] REQ_REMOVE  = 3'd3;
  localparam logic [2:0] REQ_SET_PIN = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_NO_VICTIM      = 2'd1;
  localparam logic [1:0] ST_NOT_LISTED     = 2'd2;
  localparam logic [1:0] ST_ALREADY_LISTED = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [FRAME_W-1:0] frame;
    logic [7:0]         pin_value;
  } lvl_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] victim_frame;
    logic [6:0]         occupancy;
  } lvl_out_t;

  // Write strobes from the sequencer to the frame store.
  typedef struct packed {
    logic newer_we;
    logic older_we;
    logic listed_we;
    logic listed_val;
    logic pins_we;
  } lvl_wr_en_t;

endpackage

// ===== rtl/lvl_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvl_store
// Per-frame memories: newer and older links, listed flags and pin counts,
// with one shared registered read address and a clearing pass after reset.
// ----------------------------------------------------------------------------
module lvl_store
  import lvl_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(NUM_FRAMES)-1:0] rd_addr,
  input  lvl_wr_en_t                    wr_en,
  input  logic [$clog2(NUM_FRAMES)-1:0] newer_waddr,
  input  logic [$clog2(NUM_FRAMES)-1:0] newer_wdata,
  input  logic [$clog2(NUM_FRAMES)-1:0] older_waddr,
  input  logic [$clog2(NUM_FRAMES)-1:0] older_wdata,
  input  logic [$clog2(NUM_FRAMES)-1:0] flag_waddr,
  input  logic [7:0]                    pins_wdata,
  output logic [$clog2(NUM_FRAMES)-1:0] rd_newer,
  output logic [$clog2(NUM_FRAMES)-1:0] rd_older,
  output logic                          rd_listed,
  output logic [7:0]                    rd_pins,
  output logic                          busy
);

  localparam int AW = $clog2(NUM_FRAMES);

  logic [AW-1:0] newer_mem  [NUM_FRAMES];
  logic [AW-1:0] older_mem  [NUM_FRAMES];
  logic          listed_mem [NUM_FRAMES];
  logic [7:0]    pins_mem   [NUM_FRAMES];

  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clearing_r, clearing_nxt;

  logic          listed_we, pins_we, listed_wval;
  logic [AW-1:0] flag_addr;
  logic [7:0]    pins_wval;

  // The clearing pass owns the flag and pin ports until it is done.
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(NUM_FRAMES - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  assign listed_we   = clearing_r | wr_en.listed_we;
  assign pins_we     = clearing_r | wr_en.pins_we;
  assign listed_wval = clearing_r ? 1'b0 : wr_en.listed_val;
  assign pins_wval   = clearing_r ? 8'd0 : pins_wdata;
  assign flag_addr   = clearing_r ? clr_idx_r : flag_waddr;
  assign busy        = clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en.newer_we) begin
      newer_mem[newer_waddr] <= newer_wdata;
    end
    if (wr_en.older_we) begin
      older_mem[older_waddr] <= older_wdata;
    end
    if (listed_we) begin
      listed_mem[flag_addr] <= listed_wval;
    end
    if (pins_we) begin
      pins_mem[flag_addr] <= pins_wval;
    end
    rd_newer  <= newer_mem[rd_addr];
    rd_older  <= older_mem[rd_addr];
    rd_listed <= listed_mem[rd_addr];
    rd_pins   <= pins_mem[rd_addr];
  end

endmodule

// ===== rtl/lvl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvl_seq
// Request sequencer: looks up a frame, walks from the tail for a victim,
// and unlinks or links frames through the shared store ports.
// ----------------------------------------------------------------------------
module lvl_seq
  import lvl_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lvl_in_t                       in_data,
  input  logic                          res_room,
  output logic                          fin_valid,
  output lvl_out_t                      fin_data,
  input  logic                          busy,
  output logic [$clog2(NUM_FRAMES)-1:0] rd_addr,
  output lvl_wr_en_t                    wr_en,
  output logic [$clog2(NUM_FRAMES)-1:0] newer_waddr,
  output logic [$clog2(NUM_FRAMES)-1:0] newer_wdata,
  output logic [$clog2(NUM_FRAMES)-1:0] older_waddr,
  output logic [$clog2(NUM_FRAMES)-1:0] older_wdata,
  output logic [$clog2(NUM_FRAMES)-1:0] flag_waddr,
  output logic [7:0]                    pins_wdata,
  input  logic [$clog2(NUM_FRAMES)-1:0] rd_newer,
  input  logic [$clog2(NUM_FRAMES)-1:0] rd_older,
  input  logic                          rd_listed,
  input  logic [7:0]                    rd_pins
);

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int XW = ((AW > FRAME_W) ? AW : FRAME_W) + 1;
  localparam int VW = (AW > FRAME_W) ? AW : FRAME_W;
  localparam int OW = (CW > 7) ? CW : 7;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOK   = 6'b000010,
    S_WALK   = 6'b000100,
    S_UNLINK = 6'b001000,
    S_LINK   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [2:0]    req_r, req_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          in_range_r, in_range_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [AW-1:0] victim_r, victim_nxt;
  logic [AW-1:0] target_r, target_nxt;
  logic [AW-1:0] nw_r, nw_nxt;
  logic [AW-1:0] od_r, od_nxt;
  logic [AW-1:0] walk_p_r, walk_p_nxt;
  logic [CW-1:0] walk_i_r, walk_i_nxt;

  logic [XW-1:0] frame_x;
  logic [AW-1:0] in_addr;
  logic          in_rng;
  logic          is_head, is_tail;
  logic [VW-1:0] victim_x;
  logic [OW-1:0] occ_x;

  assign frame_x = XW'(in_data.frame);
  assign in_addr = frame_x[AW-1:0];
  assign in_rng  = frame_x < XW'(NUM_FRAMES);
  assign is_head = (target_r == head_r);
  assign is_tail = (target_r == tail_r);

  assign in_ready  = (state_r == S_IDLE) && !busy;
  assign fin_valid = (state_r == S_FINISH);
  assign victim_x  = VW'(victim_r);
  assign occ_x     = OW'(count_r);

  always_comb begin
    fin_data.status       = status_r;
    fin_data.victim_frame = victim_x[FRAME_W-1:0];
    fin_data.occupancy    = occ_x[6:0];
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    req_nxt      = req_r;
    addr_nxt     = addr_r;
    in_range_nxt = in_range_r;
    status_nxt   = status_r;
    victim_nxt   = victim_r;
    target_nxt   = target_r;
    nw_nxt       = nw_r;
    od_nxt       = od_r;
    walk_p_nxt   = walk_p_r;
    walk_i_nxt   = walk_i_r;
    rd_addr      = addr_r;
    wr_en        = '0;
    newer_waddr  = '0;
    newer_wdata  = '0;
    older_waddr  = '0;
    older_wdata  = '0;
    flag_waddr   = target_r;
    pins_wdata   = in_data.pin_value;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = in_addr;
        if (in_valid && !busy) begin
          req_nxt      = in_data.req_type;
          addr_nxt     = in_addr;
          in_range_nxt = in_rng;
          status_nxt   = ST_OK;
          victim_nxt   = '0;
          unique case (in_data.req_type)
            REQ_INSERT, REQ_TOUCH, REQ_REMOVE: begin
              state_nxt = S_LOOK;
            end
            REQ_EVICT: begin
              // The walk starts at the least-recent end.
              rd_addr    = tail_r;
              walk_p_nxt = tail_r;
              walk_i_nxt = '0;
              if (count_r == '0) begin
                status_nxt = ST_NO_VICTIM;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_WALK;
              end
            end
            REQ_SET_PIN: begin
              wr_en.pins_we = in_rng;
              flag_waddr    = in_addr;
              state_nxt     = S_FINISH;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      S_LOOK: begin
        target_nxt = addr_r;
        nw_nxt     = rd_newer;
        od_nxt     = rd_older;
        unique case (req_r)
          REQ_INSERT: begin
            if (!in_range_r) begin
              status_nxt = ST_NOT_LISTED;
              state_nxt  = S_FINISH;
            end else if (rd_listed) begin
              status_nxt = ST_ALREADY_LISTED;
              state_nxt  = S_FINISH;
            end else begin
              state_nxt = S_LINK;
            end
          end
          REQ_TOUCH: begin
            if (!(in_range_r && rd_listed)) begin
              status_nxt = ST_NOT_LISTED;
              state_nxt  = S_FINISH;
            end else if (addr_r == head_r) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_UNLINK;
            end
          end
          default: begin
            if (!(in_range_r && rd_listed)) begin
              status_nxt = ST_NOT_LISTED;
              state_nxt  = S_FINISH;
            end else begin
              state_nxt = S_UNLINK;
            end
          end
        endcase
      end

      S_WALK: begin
        // Read data belongs to walk_p_r; the next read follows its newer link.
        rd_addr = rd_newer;
        if (rd_pins == 8'd0) begin
          target_nxt = walk_p_r;
          victim_nxt = walk_p_r;
          nw_nxt     = rd_newer;
          od_nxt     = rd_older;
          state_nxt  = S_UNLINK;
        end else if (walk_i_r == CW'(count_r - CW'(1))) begin
          status_nxt = ST_NO_VICTIM;
          state_nxt  = S_FINISH;
        end else begin
          walk_p_nxt = rd_newer;
          walk_i_nxt = walk_i_r + CW'(1);
        end
      end

      S_UNLINK: begin
        if (!is_head && !is_tail) begin
          wr_en.older_we = 1'b1;
          older_waddr    = nw_r;
          older_wdata    = od_r;
          wr_en.newer_we = 1'b1;
          newer_waddr    = od_r;
          newer_wdata    = nw_r;
        end else if (!is_head) begin
          tail_nxt = nw_r;
        end else if (!is_tail) begin
          head_nxt = od_r;
        end
        wr_en.listed_we  = 1'b1;
        wr_en.listed_val = 1'b0;
        count_nxt        = count_r - CW'(1);
        state_nxt        = (req_r == REQ_TOUCH) ? S_LINK : S_FINISH;
      end

      S_LINK: begin
        if (count_r == '0) begin
          head_nxt = target_r;
          tail_nxt = target_r;
        end else begin
          wr_en.newer_we = 1'b1;
          newer_waddr    = head_r;
          newer_wdata    = target_r;
          wr_en.older_we = 1'b1;
          older_waddr    = target_r;
          older_wdata    = head_r;
          head_nxt       = target_r;
        end
        wr_en.listed_we  = 1'b1;
        wr_en.listed_val = 1'b1;
        count_nxt        = count_r + CW'(1);
        state_nxt        = S_FINISH;
      end

      S_FINISH: begin
        if (res_room) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    in_range_r <= in_range_nxt;
    status_r   <= status_nxt;
    victim_r   <= victim_nxt;
    target_r   <= target_nxt;
    nw_r       <= nw_nxt;
    od_r       <= od_nxt;
    walk_p_r   <= walk_p_nxt;
    walk_i_r   <= walk_i_nxt;
  end

endmodule

// ===== rtl/lru_victim_list_with_pins.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_victim_list_with_pins
// LRU recency list over buffer frames with per-frame pin counts.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result transaction.
// Set-pin-count writes the pin count straight away; insert passes through
// the lookup and link states, remove through lookup and unlink, and touch
// through lookup, unlink and link. Evict walks from the tail past pinned
// frames and unlinks the first unpinned one. A rejected insert, touch or
// remove, and a touch of the current head, finish after the lookup; an
// evict on an empty list goes straight to the finish state, and one that
// finds every frame pinned finishes after walking all listed frames. The
// next request can be accepted in the cycle after its result is loaded.
// The walk rate is one frame per cycle, set by the registered read of the
// link and pin memories. After reset the block clears its listed flags and
// pin counts and accepts no request until that is done. A finished result
// waits in the output register while the next request runs.
module lru_victim_list_with_pins
  import lvl_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lvl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lvl_out_t out_data
);

  localparam int AW = $clog2(NUM_FRAMES);

  logic          out_valid_r, out_valid_nxt;
  lvl_out_t      out_data_r, out_data_nxt;
  logic          res_room;
  logic          fin_valid;
  lvl_out_t      fin_data;
  logic          busy;
  logic [AW-1:0] rd_addr;
  lvl_wr_en_t    wr_en;
  logic [AW-1:0] newer_waddr, newer_wdata;
  logic [AW-1:0] older_waddr, older_wdata;
  logic [AW-1:0] flag_waddr;
  logic [7:0]    pins_wdata;
  logic [AW-1:0] rd_newer, rd_older;
  logic          rd_listed;
  logic [7:0]    rd_pins;

  lvl_seq #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_room   (res_room),
    .fin_valid  (fin_valid),
    .fin_data   (fin_data),
    .busy       (busy),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .newer_waddr(newer_waddr),
    .newer_wdata(newer_wdata),
    .older_waddr(older_waddr),
    .older_wdata(older_wdata),
    .flag_waddr (flag_waddr),
    .pins_wdata (pins_wdata),
    .rd_newer   (rd_newer),
    .rd_older   (rd_older),
    .rd_listed  (rd_listed),
    .rd_pins    (rd_pins)
  );

  lvl_store #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .newer_waddr(newer_waddr),
    .newer_wdata(newer_wdata),
    .older_waddr(older_waddr),
    .older_wdata(older_wdata),
    .flag_waddr (flag_waddr),
    .pins_wdata (pins_wdata),
    .rd_newer   (rd_newer),
    .rd_older   (rd_older),
    .rd_listed  (rd_listed),
    .rd_pins    (rd_pins),
    .busy       (busy)
  );

  // The output register frees up in the same cycle its transaction is taken.
  assign res_room = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fin_valid && res_room) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fin_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/lru_victim_list_with_pins_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_victim_list_with_pins_tb
// Self-checking bench for the LRU victim list with per-frame pin counts.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel. A behavioral copy of the
// recency list, with its own link stores and pin counts, predicts every reply
// at the edge where the request is accepted. Each reply from the block is
// checked against the oldest prediction. Directed tests cover the corner
// cases. Random traffic, mostly legal operations on the current list, then
// runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module lru_victim_list_with_pins_tb;
  import lvl_pkg::*;

  localparam int N_FRAMES = 64;
  localparam int REQ_CODE_MAX = 7;
  localparam int MAX_REPORTS = 10;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lvl_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lvl_out_t out_data;

  // Predicted state of the recency list.
  bit [FRAME_W-1:0] frame_newer [N_FRAMES];
  bit [FRAME_W-1:0] frame_older [N_FRAMES];
  bit               frame_listed [N_FRAMES];
  bit [7:0]         frame_pins [N_FRAMES];
  bit [FRAME_W-1:0] lru_head;
  bit [FRAME_W-1:0] lru_tail;
  int               lru_count;

  lvl_out_t expected_replies[$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_stall_pct;

  lru_victim_list_with_pins #(
    .NUM_FRAMES(N_FRAMES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void unlink_frame(bit [FRAME_W-1:0] f);
    bit [FRAME_W-1:0] nw;
    bit [FRAME_W-1:0] od;
    nw = frame_newer[f];
    od = frame_older[f];
    if (f != lru_head && f != lru_tail) begin
      frame_older[nw] = od;
      frame_newer[od] = nw;
    end else if (f != lru_head) begin
      lru_tail = nw;
    end else if (f != lru_tail) begin
      lru_head = od;
    end
    frame_listed[f] = 1'b0;
    lru_count--;
  endfunction

  function automatic void link_frame_at_head(bit [FRAME_W-1:0] f);
    if (lru_count == 0) begin
      lru_head = f;
      lru_tail = f;
    end else begin
      frame_newer[lru_head] = f;
      frame_older[f] = lru_head;
      lru_head = f;
    end
    frame_listed[f] = 1'b1;
    lru_count++;
  endfunction

  // Applies one request to the predicted list and returns the expected reply.
  function automatic lvl_out_t apply_lru_request(lvl_in_t req);
    lvl_out_t         res;
    bit [FRAME_W-1:0] f;
    bit [FRAME_W-1:0] p;
    bit               found;
    int               steps;
    res = '0;
    f = req.frame;
    case (req.req_type)
      REQ_INSERT: begin
        if (frame_listed[f]) res.status = ST_ALREADY_LISTED;
        else link_frame_at_head(f);
      end
      REQ_TOUCH: begin
        if (!frame_listed[f]) begin
          res.status = ST_NOT_LISTED;
        end else if (f != lru_head) begin
          unlink_frame(f);
          link_frame_at_head(f);
        end
      end
      REQ_EVICT: begin
        // Walk from the least recent end to the first unpinned frame.
        p = lru_tail;
        found = 1'b0;
        steps = 0;
        while (!found && steps < lru_count) begin
          if (frame_pins[p] == 8'd0) begin
            found = 1'b1;
          end else begin
            p = frame_newer[p];
            steps++;
          end
        end
        if (found) begin
          unlink_frame(p);
          res.victim_frame = p;
        end else begin
          res.status = ST_NO_VICTIM;
        end
      end
      REQ_REMOVE: begin
        if (!frame_listed[f]) res.status = ST_NOT_LISTED;
        else unlink_frame(f);
      end
      REQ_SET_PIN: frame_pins[f] = req.pin_value;
      default: ;
    endcase
    res.occupancy = 7'(lru_count);
    return res;
  endfunction

  function automatic bit [FRAME_W-1:0] pick_frame(bit want_listed);
    bit [FRAME_W-1:0] candidates[$];
    for (int i = 0; i < N_FRAMES; i++) begin
      if (frame_listed[i] == want_listed) candidates.push_back(FRAME_W'(i));
    end
    if (candidates.size() == 0) return FRAME_W'($urandom_range(N_FRAMES - 1));
    return candidates[$urandom_range(candidates.size() - 1)];
  endfunction

  function automatic bit [7:0] pick_pin_count();
    if ($urandom_range(99) < 60) return 8'd0;
    return 8'($urandom_range(255, 1));
  endfunction

  // Drives one request and records its prediction once the block takes it.
  task automatic send_request(input logic [2:0] kind, input int frame, input int pin);
    lvl_in_t req;
    req.req_type = kind;
    req.frame = FRAME_W'(frame);
    req.pin_value = 8'(pin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_replies.push_back(apply_lru_request(req));
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    lvl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected reply: status %0d victim %0d occupancy %0d",
                   out_data.status, out_data.victim_frame, out_data.occupancy);
      end else begin
        want = expected_replies.pop_front();
        if (out_data.status !== want.status ||
            out_data.victim_frame !== want.victim_frame ||
            out_data.occupancy !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("reply differs: status %0d/%0d victim %0d/%0d occupancy %0d/%0d",
                     want.status, out_data.status, want.victim_frame,
                     out_data.victim_frame, want.occupancy, out_data.occupancy);
        end
      end
    end
  end

  task automatic test_empty_list();
    send_request(REQ_EVICT, 0, 0);
    send_request(REQ_TOUCH, 5, 0);
    send_request(REQ_REMOVE, 63, 255);
    send_request(REQ_SET_PIN, 0, 0);
    for (int r = REQ_SET_PIN + 1; r <= REQ_CODE_MAX; r++) begin
      send_request(3'(r), 63, 255);
    end
  endtask

  // Filling every frame writes the newer link of all frames but the last
  // and the older link of all but the first, so walks follow written links.
  task automatic test_fill_and_drain();
    for (int f = 0; f < N_FRAMES; f++) send_request(REQ_INSERT, f, 0);
    send_request(REQ_INSERT, 63, 0);
    send_request(REQ_TOUCH, 0, 0);
    send_request(REQ_TOUCH, 0, 0);
    send_request(REQ_TOUCH, 30, 0);
    send_request(REQ_SET_PIN, 1, 255);
    send_request(REQ_EVICT, 0, 0);
    send_request(REQ_REMOVE, 30, 0);
    send_request(REQ_REMOVE, 1, 0);
    send_request(REQ_REMOVE, 10, 0);
    send_request(REQ_SET_PIN, 1, 0);
    while (lru_count > 0) send_request(REQ_EVICT, 0, 0);
    send_request(REQ_EVICT, 0, 0);
  endtask

  task automatic test_pinned_walk();
    send_request(REQ_INSERT, 40, 0);
    send_request(REQ_SET_PIN, 40, 1);
    send_request(REQ_EVICT, 0, 0);
    send_request(REQ_INSERT, 41, 0);
    send_request(REQ_INSERT, 42, 0);
    send_request(REQ_SET_PIN, 41, 128);
    send_request(REQ_SET_PIN, 42, 255);
    send_request(REQ_EVICT, 0, 0);
    // Only the most recent frame is free, so the walk covers the whole list.
    send_request(REQ_SET_PIN, 42, 0);
    send_request(REQ_EVICT, 0, 0);
    send_request(REQ_REMOVE, 40, 0);
    send_request(REQ_REMOVE, 41, 0);
    send_request(REQ_SET_PIN, 40, 0);
    send_request(REQ_SET_PIN, 41, 0);
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int stall_pct);
    int dice;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      dice = $urandom_range(99);
      if (dice < 30) begin
        send_request(REQ_INSERT, pick_frame(1'b0), $urandom_range(255));
      end else if (dice < 50) begin
        send_request(REQ_TOUCH, pick_frame(1'b1), $urandom_range(255));
      end else if (dice < 62) begin
        send_request(REQ_EVICT, $urandom_range(N_FRAMES - 1), $urandom_range(255));
      end else if (dice < 72) begin
        send_request(REQ_REMOVE, pick_frame(1'b1), $urandom_range(255));
      end else if (dice < 88) begin
        send_request(REQ_SET_PIN,
                     $urandom_range(1) ? pick_frame(1'b1) : $urandom_range(N_FRAMES - 1),
                     pick_pin_count());
      end else begin
        send_request(3'($urandom_range(REQ_CODE_MAX)), $urandom_range(N_FRAMES - 1),
                     $urandom_range(255));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    lru_head = '0;
    lru_tail = '0;
    lru_count = 0;
    send_idle_pct = 13;
    recv_stall_pct = 13;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_and_drain();
    test_pinned_walk();
    test_random_traffic(160, 0, 0);
    test_random_traffic(160, 88, 0);
    test_random_traffic(160, 0, 88);
    test_random_traffic(160, 13, 13);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (N_FRAMES + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lru_victim_list_with_pins: match");
    end else begin
      $display("lru_victim_list_with_pins: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("lru_victim_list_with_pins: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lvl_pkg.sv
rtl/lvl_store.sv
rtl/lvl_seq.sv
rtl/lru_victim_list_with_pins.sv
sim/lru_victim_list_with_pins_tb.sv
